// ===== src/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 message hasher
// Holds the controller states, the command and status bundles, the round
// constants, the initial hash vector and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_LEN,
    S_OUT
  } sha_state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD_FIRST,
    PH_FINAL
  } sha_phase_t;

  typedef struct packed {
    logic       byte_wr;
    logic       load;
    logic       round;
    logic       add;
    logic       pad;
    logic       len;
    logic       len_clear;
    logic       restart;
    logic [5:0] rnd;
  } sha_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic pad_two;
  } sha_status_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] PAD_LIMIT = 6'd56;

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== src/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha_ctrl: sequencer of the SHA-256 message hasher
// Accepts bytes, steps the datapath through load, rounds, padding and the
// length word, and walks the eight digest words out.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 has_byte,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           word_index,
  output logic                 last_word,
  output sha_pkg::sha_cmd_t    cmd,
  input  sha_pkg::sha_status_t status
);
  import sha_pkg::*;

  sha_state_t state, state_next;
  sha_phase_t phase, phase_next;
  logic       last_pend, last_pend_next;
  logic [5:0] rnd, rnd_next;
  logic [2:0] widx, widx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_DATA;
      last_pend <= 1'b0;
      rnd       <= '0;
      widx      <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      last_pend <= last_pend_next;
      rnd       <= rnd_next;
      widx      <= widx_next;
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    last_pend_next = last_pend;
    rnd_next       = rnd;
    widx_next      = widx;
    cmd            = '0;
    cmd.rnd        = rnd;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.byte_wr    = has_byte;
          last_pend_next = last;
          phase_next     = PH_DATA;
          if (has_byte && status.fill_last) begin
            state_next = S_LOAD;
          end else if (last) begin
            state_next = S_PAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        rnd_next   = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == 6'd63) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add = 1'b1;
        case (phase)
          PH_DATA:      state_next = last_pend ? S_PAD : S_IDLE;
          PH_PAD_FIRST: state_next = S_LEN;
          PH_FINAL: begin
            widx_next  = '0;
            state_next = S_OUT;
          end
          default:      state_next = S_IDLE;
        endcase
      end
      S_PAD: begin
        cmd.pad = 1'b1;
        if (status.pad_two) begin
          phase_next = PH_PAD_FIRST;
          state_next = S_LOAD;
        end else begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.len       = 1'b1;
        cmd.len_clear = (phase == PH_PAD_FIRST);
        phase_next    = PH_FINAL;
        state_next    = S_LOAD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          widx_next = widx + 3'd1;
          if (widx == 3'd7) begin
            cmd.restart    = 1'b1;
            last_pend_next = 1'b0;
            state_next     = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign word_index = widx;
  assign last_word  = (widx == 3'd7);

endmodule

// ===== src/sha_dp.sv =====
// ----------------------------------------------------------------------------
// sha_dp: datapath of the SHA-256 message hasher
// Holds the sixteen-word block and schedule window, the working variables,
// the chaining value and the byte counters; one round per command.
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  sha_pkg::sha_cmd_t    cmd,
  input  logic [2:0]           word_index,
  output logic [31:0]          digest_word,
  output sha_pkg::sha_status_t status
);
  import sha_pkg::*;

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];
  logic [5:0]  fill;
  logic [60:0] msg;

  logic [31:0] w_new, t1, t2;
  logic [63:0] bits;

  assign w_new = w[0] + ssig0(w[1]) + w[9] + ssig1(w[14]);
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[cmd.rnd] + w[0];
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign bits = {msg, 3'b000};

  // Block window: bytes land big-endian; rounds shift the window by one word.
  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      w[fill[5:2]][8 * (3 - fill[1:0]) +: 8] <= data_byte;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_new;
    end else if (cmd.pad) begin
      for (int i = 0; i < 64; i++) begin
        if (6'(i) == fill) begin
          w[i / 4][8 * (3 - (i % 4)) +: 8] <= PAD_BYTE;
        end else if (6'(i) > fill) begin
          w[i / 4][8 * (3 - (i % 4)) +: 8] <= 8'h00;
        end
      end
    end else if (cmd.len) begin
      if (cmd.len_clear) begin
        for (int i = 0; i < 14; i++) begin
          w[i] <= '0;
        end
      end
      w[14] <= bits[63:32];
      w[15] <= bits[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= h[i];
      end
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        h[i] <= IV_TAB[i];
      end
      fill <= '0;
      msg  <= '0;
    end else begin
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) begin
          h[i] <= h[i] + v[i];
        end
      end
      if (cmd.byte_wr) begin
        fill <= fill + 6'd1;
        msg  <= msg + 61'd1;
      end
    end
  end

  assign digest_word      = h[word_index];
  assign status.fill_last = (fill == 6'd63);
  assign status.pad_two   = (fill >= PAD_LIMIT);

endmodule

// ===== src/sha256_message_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher_top: SHA-256 of a byte stream
// Collects message bytes into 64-byte blocks, compresses each full block,
// pads the message on its end marker and returns the digest as eight words.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------
//  input    in_valid / in_ready  data_byte[7:0], has_byte, last
//  output   out_valid/out_ready  digest_word[31:0], word_index[2:0], last_word
//
// While the block is collecting, each byte transaction is accepted as it is
// offered. The transaction that fills a block holds off further input
// through one load, 64 rounds of the single shared round unit and one
// chaining add. The end of a message costs a pad step, a length step and
// one or two compressions (two when 56 or more bytes sit in the last block),
// then the eight digest words, one per accepted output transaction.
// Reset returns the chaining value to the initial vector and clears the
// byte counters. A stalled output simply holds the current digest word;
// no new input is taken until the last word has been accepted.
module sha256_message_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_status_t status;

  // The controller owns all sequencing; the datapath only follows commands.
  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .has_byte   (has_byte),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_index (word_index),
    .last_word  (last_word),
    .cmd        (cmd),
    .status     (status)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .word_index  (word_index),
    .digest_word (digest_word),
    .status      (status)
  );

endmodule

// ===== src/sha_checker.sv =====
// ----------------------------------------------------------------------------
// sha_checker: port-level checks for the SHA-256 message hasher
// Watches the handshakes and the digest word sequencing on the top level.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // A waiting digest word must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word))
    else $error("digest word changed while stalled");

  // Input is never taken while a digest is being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input ready during digest output");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (last_word != (word_index == 3'd7)) |-> 1'b0)
    else $error("last_word does not match word 7");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest words out of sequence");

  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> !out_valid)
    else $error("output continued after last digest word");

endmodule

bind sha256_message_hasher_top sha_checker u_sha_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last_word   (last_word)
);
